// ===== rtl/core/b2da_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds widths, codes, the cell control type and the state type; no dependencies.

package b2da_pkg;

   localparam int ValueWidth = 32;
   localparam int NumDigits  = 10;
   localparam int DigitWidth = 4;
   localparam int CharWidth  = 6;
   localparam int CountWidth = $clog2(ValueWidth);
   localparam int LeftWidth  = $clog2(NumDigits + 1);

   localparam logic [CharWidth-1:0]  AsciiZero = 6'd48;
   localparam logic [DigitWidth-1:0] AdjustMin = 4'd5;
   localparam logic [DigitWidth-1:0] AdjustAdd = 4'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_CONVERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/b2da_if.sv =====
// Channel interfaces for the binary to decimal ASCII converter.
// Depends on b2da_pkg for the payload widths.

interface b2da_req_if import b2da_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if import b2da_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] digit_char;
   logic                 last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/core/b2da_cell.sv =====
// One BCD digit cell of the shift-add-3 chain.
// Depends on b2da_pkg for widths and the cell control type.

module b2da_cell import b2da_pkg::*; (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic                  conv_in,
   input  logic [DigitWidth-1:0] shift_digit,
   output logic                  carry_out,
   output logic [DigitWidth-1:0] digit_out
);

   logic [DigitWidth-1:0] digit_ff;
   logic [DigitWidth-1:0] digit_in;
   logic [DigitWidth-1:0] adj;

   // add 3 before the shift so a digit of 5 or more carries into the neighbor
   assign adj       = (digit_ff >= AdjustMin) ? digit_ff + AdjustAdd : digit_ff;
   assign carry_out = adj[DigitWidth-1];
   assign digit_out = digit_ff;

   always_comb begin
      case (ctrl.op)
         CELL_CLEAR:   digit_in = '0;
         CELL_CONVERT: digit_in = {adj[DigitWidth-2:0], conv_in};
         CELL_SHIFT:   digit_in = shift_digit;
         default:      digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII: a 32-bit unsigned number in, 1 to 10 digit beats out.
// Steps: accept, convert (one input bit per cycle through ten BCD cells), drop
// leading zeros, then emit one digit per cycle while the sink keeps up; a new
// number is taken only in idle, once the last digit of the one before has loaded.
// Synchronous reset returns to idle with no beat pending. Depends on b2da_pkg,
// b2da_if and b2da_cell.

module binary_to_decimal_ascii import b2da_pkg::*; (
   input logic       clock,
   input logic       reset,
   b2da_req_if.sink  req_bus,
   b2da_rsp_if.source rsp_bus
);

   state_type state_ff, state_in;

   // binary operand, shifted out MSB first into the lowest cell
   logic [ValueWidth-1:0] bin_ff, bin_in;
   // convert step counter, 0 to 31
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   // digits still in the chain that may be emitted, 0 to 10
   logic [LeftWidth-1:0]  left_ff, left_in;

   // output register, parts the cell chain from the sink
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         cell_ctrl;
   logic                  req_take;
   logic                  rsp_load;
   logic                  rsp_free;

   logic [NumDigits-1:0]  carry;
   logic [NumDigits-1:0]  conv_in;
   logic [DigitWidth-1:0] digit   [NumDigits];
   logic [DigitWidth-1:0] shift_in[NumDigits];
   logic [DigitWidth-1:0] top_digit;

   assign top_digit = digit[NumDigits-1];

   // ---------------------------------------------------------------------
   // Cell chain. In convert, each cell takes the carry of the cell below and the
   // lowest takes the next operand bit; in shift, each cell takes the digit below,
   // so the top cell always holds the next digit to emit.
   // ---------------------------------------------------------------------
   assign conv_in = {carry[NumDigits-2:0], bin_ff[ValueWidth-1]};

   for (genvar i = 0; i < NumDigits; i++) begin : g_cell
      if (i == 0) begin : g_low
         assign shift_in[i] = '0;
      end else begin : g_up
         assign shift_in[i] = digit[i-1];
      end

      b2da_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .conv_in     (conv_in[i]),
         .shift_digit (shift_in[i]),
         .carry_out   (carry[i]),
         .digit_out   (digit[i])
      );
   end

   // ---------------------------------------------------------------------
   // Handshakes. The sink side frees the output register when its beat is
   // taken, so a new digit can load in the same cycle.
   // ---------------------------------------------------------------------
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign req_take           = req_bus.valid && req_bus.ready;
   assign rsp_free           = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.digit_char = rsp_char_ff;
   assign rsp_bus.last       = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Sequencer: next state, cell control and output register loads.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      cell_ctrl.op = CELL_HOLD;
      rsp_load     = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bin_in       = req_bus.value;
               cnt_in       = '0;
               cell_ctrl.op = CELL_CLEAR;
               state_in     = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // shift one binary bit into the chain per cycle
            cell_ctrl.op = CELL_CONVERT;
            bin_in       = {bin_ff[ValueWidth-2:0], 1'b0};
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CountWidth'(ValueWidth - 1)) begin
               left_in  = LeftWidth'(NumDigits);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, but always keep the units digit
            if (top_digit == '0 && left_ff != LeftWidth'(1)) begin
               cell_ctrl.op = CELL_SHIFT;
               left_in      = left_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_char_in  = AsciiZero + CharWidth'(top_digit);
               rsp_last_in  = (left_ff == LeftWidth'(1));
               cell_ctrl.op = CELL_SHIFT;
               left_in      = left_ff - 1'b1;
               if (left_ff == LeftWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and counters, qualified by state
   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      left_ff     <= left_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_top_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> top_digit <= 4'd9)
      else $error("top cell holds a non-BCD digit");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (left_ff != '0 && left_ff <= LeftWidth'(NumDigits)))
      else $error("digit count out of range while emitting");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("last beat loaded without returning to idle");

   a_skip_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP && state_in == ST_EMIT)
         |-> (top_digit != '0 || left_ff == LeftWidth'(1)))
      else $error("leading zero left in front of the number");

   // a 32-bit number never overflows ten decimal digits
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> !carry[NumDigits-1])
      else $error("top cell carried out during conversion");

endmodule

// ===== dv/binary_to_decimal_ascii_checker.sv =====
`timescale 1ns / 1ps
// Checker for binary_to_decimal_ascii: watches both channels, predicts the digit beats.
// Depends on b2da_pkg for widths and the ASCII base.

module binary_to_decimal_ascii_checker import b2da_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [ValueWidth-1:0] req_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [CharWidth-1:0] rsp_digit_char,
   input  logic                 rsp_last,
   output int                   fail_count,
   output int                   digits_pending,
   output int                   digits_checked
);

   localparam int Radix = 10;

   typedef struct packed {
      logic [CharWidth-1:0] digit_char;
      logic                 last;
   } digit_beat_type;

   digit_beat_type expected_digits[$];
   int             mismatches = 0;
   int             beats_seen = 0;

   // Split the number into decimal digits, drop leading zeros, queue MSD first.
   function automatic void queue_digits(input logic [ValueWidth-1:0] number);
      logic [DigitWidth-1:0] dec [NumDigits];
      logic [ValueWidth-1:0] rest;
      int                    top_digit;
      digit_beat_type        beat;
      rest      = number;
      top_digit = 0;
      for (int i = 0; i < NumDigits; i++) begin
         dec[i] = DigitWidth'(rest % Radix);
         rest   = rest / Radix;
         if (dec[i] != 0) top_digit = i;
      end
      for (int i = top_digit; i >= 0; i--) begin
         beat.digit_char = AsciiZero + CharWidth'(dec[i]);
         beat.last       = (i == 0);
         expected_digits.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin : watch
      digit_beat_type want;
      if (!reset) begin
         // check the result beat before queueing a new number
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $error("digit beat with no number pending: digit_char=%0d last=%0b",
                      rsp_digit_char, rsp_last);
               mismatches++;
            end else begin
               want = expected_digits.pop_front();
               beats_seen++;
               if (rsp_digit_char !== want.digit_char) begin
                  $error("digit_char mismatch: expected %0d, actual %0d",
                         want.digit_char, rsp_digit_char);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) queue_digits(req_value);
      end
      fail_count     <= mismatches;
      digits_pending <= expected_digits.size();
      digits_checked <= beats_seen;
   end

endmodule

// ===== dv/binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps
// Top of the binary_to_decimal_ascii testbench: clock, reset, stimulus and verdict.
// Depends on b2da_pkg, b2da_if, the block itself and binary_to_decimal_ascii_checker.

module binary_to_decimal_ascii_test;
   import b2da_pkg::*;

   localparam int RandomNumbers = 500;
   localparam int DrainLimit    = 20000;   // cycles allowed for the last digits to come out
   localparam int SettleCycles  = 60;      // a bit more than the slowest single number

   logic clock = 1'b0;
   logic reset;

   b2da_req_if req_bus ();
   b2da_rsp_if rsp_bus ();

   int  fail_count;
   int  digits_pending;
   int  digits_checked;
   int  numbers_sent = 0;
   bit  sender_gaps  = 1'b1;

   // Directed numbers: zero, one-digit edges, every digit count but four, the 32-bit
   // extremes, numbers around the largest power of ten and alternating bits.
   logic [ValueWidth-1:0] directed_values [$] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd65535,
      32'd100000, 32'd9999999, 32'd10000000,
      32'd999999999, 32'd1000000000, 32'd1000000001,
      32'd1234567890, 32'd2147483647, 32'd2147483648,
      32'd3999999999, 32'd4000000000, 32'd4294967290,
      32'd4294967294, 32'd4294967295, 32'hAAAAAAAA, 32'h55555555
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   binary_to_decimal_ascii u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   binary_to_decimal_ascii_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_value      (req_bus.value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_digit_char (rsp_bus.digit_char),
      .rsp_last       (rsp_bus.last),
      .fail_count     (fail_count),
      .digits_pending (digits_pending),
      .digits_checked (digits_checked)
   );

   // Mix full-range numbers, short numbers of every length, and numbers
   // right around a power of ten where the digit count changes.
   function automatic logic [ValueWidth-1:0] pick_number();
      logic [ValueWidth-1:0] power;
      int                    pick;
      pick  = $urandom_range(9);
      power = 1;
      if (pick < 4) begin
         return $urandom;
      end else if (pick < 7) begin
         return $urandom >> $urandom_range(ValueWidth - 1);
      end else begin
         repeat ($urandom_range(NumDigits - 1)) power = power * 10;
         return power + $urandom_range(2) - 1;
      end
   endfunction

   // Offer one number and hold it until the block takes the beat. Leave valid
   // high on return so back-to-back numbers need no extra assignment.
   task automatic send_number(input logic [ValueWidth-1:0] number);
      if (sender_gaps && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= $urandom;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= number;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      numbers_sent++;
   endtask

   // Result side: random stalls, one long hold that backs the block up while
   // numbers keep coming, and a long stretch of ready held high.
   initial begin : digit_sink
      int cycle_no;
      int hold_left;
      cycle_no      = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         cycle_no++;
         if (cycle_no == 2000) hold_left = 400;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (cycle_no >= 6000 && cycle_no < 10000) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 10);
         end
         @(posedge clock);
      end
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int wait_cycles;
      int failures;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) send_number(directed_values[i]);

      // Turn sender gaps off for a block of numbers in the middle.
      for (int n = 0; n < RandomNumbers; n++) begin
         sender_gaps = (n < 200 || n >= 300);
         send_number(pick_number());
      end
      req_bus.valid <= 1'b0;

      // Drain: wait for every predicted digit, then let the block settle.
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (digits_pending != 0 && wait_cycles < DrainLimit);
      repeat (SettleCycles) @(posedge clock);

      failures = fail_count;
      if (digits_pending != 0) begin
         $error("%0d predicted digit beats never arrived", digits_pending);
         failures++;
      end

      $display("Converted %0d numbers: zero, 32-bit extremes, power-of-ten edges, random widths.",
               numbers_sent);
      $display("Checked %0d digit beats under random stalls and one long output hold.",
               digits_checked);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
